@@ hdl/cfpf_pkg.sv @@
// Shared types and constants for the coordinate frame parser and filter.
// Used by the top module, cfpf_front and cfpf_back; no dependencies of its own.
package cfpf_pkg;

  localparam int FIELD_CHARS_DEF = 9;
  localparam int QUEUE_DEPTH_DEF = 2;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_START = 8'h21;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_END   = 8'h40;

  // Register reset values
  localparam logic [7:0] OFFSET_RESET = 8'd112;
  localparam logic [8:0] GAIN_RESET   = 9'd77;

  // Register indexes (paddr[2])
  localparam logic REG_CENTER_OFFSET  = 1'b0;
  localparam logic REG_SMOOTHING_GAIN = 1'b1;

  typedef struct packed {
    logic [7:0] x_value;
    logic [7:0] y_value;
  } frame_t;

  typedef enum logic [2:0] {
    F_WAIT = 3'b001,
    F_X    = 3'b010,
    F_Y    = 3'b100
  } frame_phase_t;

  typedef enum logic [3:0] {
    N_SPACE  = 4'b0001,
    N_SIGN   = 4'b0010,
    N_DIGITS = 4'b0100,
    N_STOP   = 4'b1000
  } number_phase_t;

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_MUL  = 3'b010,
    B_FIN  = 3'b100
  } back_state_t;

endpackage

@@ hdl/coordinate_frame_parser_filter.sv @@
// Parses "!x,y@" frames one byte per transaction and emits one transaction per good frame
// with both offset-corrected samples and their Q8.8 smoothed values. The parser takes one
// byte every clock; in_stall is high only while the frame queue (QUEUE_DEPTH entries) is
// full. The filter works in two steps per frame (multiply, then add and clamp) and, when the
// output is not stalled, takes the next frame from the queue in its last step.
// Registers: center_offset at 0x0, smoothing_gain at 0x4. Depends on cfpf_pkg,
// cfpf_front, cfpf_queue and cfpf_back.
module coordinate_frame_parser_filter import cfpf_pkg::*; #(
  parameter int FIELD_CHARS = FIELD_CHARS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // byte input
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  // results
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_x_smoothed,
  output logic signed [15:0] out_y_smoothed,
  output logic signed [7:0]  out_x_sample,
  output logic signed [7:0]  out_y_sample,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [7:0] center_offset_r;
  logic [8:0] smoothing_gain_r;
  logic       cfg_write;
  logic       take;
  logic       push;
  frame_t     push_frame;
  frame_t     pop_frame;
  logic       q_pop;
  logic       q_not_empty;
  logic       q_full;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_offset_r  <= OFFSET_RESET;
      smoothing_gain_r <= GAIN_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_CENTER_OFFSET) begin
        center_offset_r <= pwdata[7:0];
      end else begin
        smoothing_gain_r <= pwdata[8:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_SMOOTHING_GAIN) ? {23'd0, smoothing_gain_r}
                                                   : {24'd0, center_offset_r};

  assign in_stall = q_full;
  assign take     = in_valid && !in_stall;

  cfpf_front #(
    .FIELD_CHARS(FIELD_CHARS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .rx_byte (in_rx_byte),
    .push    (push),
    .frame   (push_frame)
  );

  cfpf_queue #(
    .WIDTH($bits(frame_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_frame),
    .pop       (q_pop),
    .pop_data  (pop_frame),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  cfpf_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .center_offset  (center_offset_r),
    .smoothing_gain (smoothing_gain_r),
    .q_valid        (q_not_empty),
    .q_frame        (pop_frame),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_x_smoothed (out_x_smoothed),
    .out_y_smoothed (out_y_smoothed),
    .out_x_sample   (out_x_sample),
    .out_y_sample   (out_y_sample)
  );

endmodule

@@ hdl/cfpf_front.sv @@
// Front end: frame and field parser, one byte per accepted transaction.
// Pushes the parsed x/y values of each good frame. Depends on cfpf_pkg.
module cfpf_front import cfpf_pkg::*; #(
  parameter int FIELD_CHARS = FIELD_CHARS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [7:0] rx_byte,
  output logic       push,
  output frame_t     frame
);

  localparam int CNT_W = $clog2(FIELD_CHARS + 1);

  frame_phase_t  frame_phase_r, frame_phase_nxt;
  number_phase_t number_phase_r, number_phase_nxt;
  logic          broken_r, broken_nxt;
  logic          neg_r, neg_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]    x_acc_r, x_acc_nxt;
  logic [7:0]    y_acc_r, y_acc_nxt;

  always_comb begin
    logic [7:0]       cur_acc;
    logic [7:0]       num_acc;
    number_phase_t    num_phase;
    logic             num_neg;
    logic [CNT_W-1:0] num_cnt;
    logic [7:0]       field_val;
    logic             is_digit;
    logic             is_space;
    logic             is_sign;

    frame_phase_nxt  = frame_phase_r;
    number_phase_nxt = number_phase_r;
    broken_nxt       = broken_r;
    neg_nxt          = neg_r;
    cnt_nxt          = cnt_r;
    x_acc_nxt        = x_acc_r;
    y_acc_nxt        = y_acc_r;
    push             = 1'b0;

    cur_acc  = (frame_phase_r == F_Y) ? y_acc_r : x_acc_r;
    is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
    is_space = rx_byte inside {[CH_TAB:CH_CR], CH_SPACE};
    is_sign  = rx_byte inside {CH_PLUS, CH_MINUS};

    // atoi-style step on the current field
    num_acc   = cur_acc;
    num_phase = number_phase_r;
    num_neg   = neg_r;
    num_cnt   = cnt_r;
    if (cnt_r < CNT_W'(FIELD_CHARS)) begin
      num_cnt = cnt_r + 1'b1;
      if (is_digit && number_phase_r != N_STOP) begin
        num_phase = N_DIGITS;
        num_acc   = (cur_acc << 3) + (cur_acc << 1) + (rx_byte - CH_ZERO);
      end else if (number_phase_r == N_SPACE && is_space) begin
        num_phase = N_SPACE;
      end else if (number_phase_r == N_SPACE && is_sign) begin
        num_neg   = (rx_byte == CH_MINUS);
        num_phase = N_SIGN;
      end else begin
        num_phase = N_STOP;
      end
    end

    field_val = neg_r ? (8'd0 - cur_acc) : cur_acc;
    frame.x_value = x_acc_r;
    frame.y_value = field_val;

    if (take) begin
      if (rx_byte == CH_START) begin
        frame_phase_nxt  = F_X;
        broken_nxt       = 1'b0;
        x_acc_nxt        = 8'd0;
        y_acc_nxt        = 8'd0;
        number_phase_nxt = N_SPACE;
        neg_nxt          = 1'b0;
        cnt_nxt          = '0;
      end else begin
        case (frame_phase_r)
          F_WAIT: begin
            frame_phase_nxt = F_WAIT;
          end
          F_X: begin
            if (rx_byte == CH_NUL) begin
              broken_nxt = 1'b1;
            end else if (rx_byte == CH_COMMA) begin
              x_acc_nxt        = field_val;
              frame_phase_nxt  = F_Y;
              number_phase_nxt = N_SPACE;
              neg_nxt          = 1'b0;
              cnt_nxt          = '0;
            end else if (rx_byte == CH_END) begin
              // no comma: frame dropped
              frame_phase_nxt  = F_WAIT;
              number_phase_nxt = N_SPACE;
              neg_nxt          = 1'b0;
              cnt_nxt          = '0;
            end else begin
              x_acc_nxt        = num_acc;
              number_phase_nxt = num_phase;
              neg_nxt          = num_neg;
              cnt_nxt          = num_cnt;
            end
          end
          F_Y: begin
            if (rx_byte == CH_NUL) begin
              broken_nxt = 1'b1;
            end else if (rx_byte == CH_END) begin
              y_acc_nxt        = field_val;
              frame_phase_nxt  = F_WAIT;
              number_phase_nxt = N_SPACE;
              neg_nxt          = 1'b0;
              cnt_nxt          = '0;
              broken_nxt       = 1'b0;
              push             = !broken_r;
            end else begin
              y_acc_nxt        = num_acc;
              number_phase_nxt = num_phase;
              neg_nxt          = num_neg;
              cnt_nxt          = num_cnt;
            end
          end
          default: begin
            frame_phase_nxt = F_WAIT;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_phase_r  <= F_WAIT;
      number_phase_r <= N_SPACE;
      broken_r       <= 1'b0;
      neg_r          <= 1'b0;
      cnt_r          <= '0;
      x_acc_r        <= 8'd0;
      y_acc_r        <= 8'd0;
    end else begin
      frame_phase_r  <= frame_phase_nxt;
      number_phase_r <= number_phase_nxt;
      broken_r       <= broken_nxt;
      neg_r          <= neg_nxt;
      cnt_r          <= cnt_nxt;
      x_acc_r        <= x_acc_nxt;
      y_acc_r        <= y_acc_nxt;
    end
  end

endmodule

@@ hdl/cfpf_queue.sv @@
// Small register FIFO between the parser and the filter.
// Depends on nothing but the width and depth parameters.
module cfpf_queue #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             not_empty,
  output logic             full
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

@@ hdl/cfpf_back.sv @@
// Back end: offset correction and Q8.8 exponential filter for both axes,
// with the output register. Depends on cfpf_pkg.
module cfpf_back import cfpf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [7:0]         center_offset,
  input  logic [8:0]         smoothing_gain,
  input  logic               q_valid,
  input  frame_t             q_frame,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_x_smoothed,
  output logic signed [15:0] out_y_smoothed,
  output logic signed [7:0]  out_x_sample,
  output logic signed [7:0]  out_y_sample
);

  localparam int DIFF_W = 18;
  localparam int PROD_W = 28;

  back_state_t state_r, state_nxt;
  frame_t      frame_r;
  logic signed [7:0]        xs_r, ys_r;
  logic signed [PROD_W-1:0] xprod_r, yprod_r;
  logic signed [15:0]       xf_r, yf_r;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [15:0]       out_xf_r, out_yf_r;
  logic signed [7:0]        out_xs_r, out_ys_r;

  logic signed [7:0]        xs, ys;
  logic signed [DIFF_W-1:0] xdiff, ydiff;
  logic signed [PROD_W-1:0] xprod, yprod;
  logic signed [15:0]       xf_new, yf_new;
  logic                     fin_go;

  // f + floor(prod / 256), clamped to int16
  function automatic logic signed [15:0] sat_update(input logic signed [15:0] f,
                                                    input logic signed [PROD_W-1:0] p);
    logic signed [20:0] r;
    r = {{5{f[15]}}, f} + {p[PROD_W-1], p[PROD_W-1:8]};
    if (r > 21'sd32767) begin
      sat_update = 16'sh7FFF;
    end else if (r < -21'sd32768) begin
      sat_update = 16'sh8000;
    end else begin
      sat_update = r[15:0];
    end
  endfunction

  always_comb begin
    xs    = $signed(center_offset - frame_r.x_value);
    ys    = $signed(center_offset - frame_r.y_value);
    xdiff = {{2{xs[7]}}, xs, 8'd0} - {{2{xf_r[15]}}, xf_r};
    ydiff = {{2{ys[7]}}, ys, 8'd0} - {{2{yf_r[15]}}, yf_r};
    xprod = $signed({1'b0, smoothing_gain}) * xdiff + 28'sd128;
    yprod = $signed({1'b0, smoothing_gain}) * ydiff + 28'sd128;
    xf_new = sat_update(xf_r, xprod_r);
    yf_new = sat_update(yf_r, yprod_r);
  end

  assign fin_go = (state_r == B_FIN) && (!out_valid_r || !out_stall);
  assign q_pop  = q_valid && ((state_r == B_IDLE) || fin_go);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (q_pop) begin
          state_nxt = B_MUL;
        end
      end
      B_MUL: begin
        state_nxt = B_FIN;
      end
      B_FIN: begin
        if (fin_go) begin
          state_nxt = q_pop ? B_MUL : B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase

    out_valid_nxt = out_valid_r;
    if (fin_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      frame_r <= q_frame;
    end
    if (state_r == B_MUL) begin
      xs_r    <= xs;
      ys_r    <= ys;
      xprod_r <= xprod;
      yprod_r <= yprod;
    end
    if (fin_go) begin
      out_xf_r <= xf_new;
      out_yf_r <= yf_new;
      out_xs_r <= xs_r;
      out_ys_r <= ys_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      xf_r        <= 16'sd0;
      yf_r        <= 16'sd0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (fin_go) begin
        xf_r <= xf_new;
        yf_r <= yf_new;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_x_smoothed = out_xf_r;
  assign out_y_smoothed = out_yf_r;
  assign out_x_sample   = out_xs_r;
  assign out_y_sample   = out_ys_r;

endmodule
